// File: rtl/core/cmf_pkg.sv
// Shared types, constants and register codes of the compact mel filterbank.
`timescale 1ns / 1ps
`default_nettype none
package cmf_pkg;

  localparam int BAND_W      = 12;
  localparam int QUEUE_DEPTH = 4;
  localparam int FRAC_SHIFT  = 31;
  localparam int MAX_SHIFT   = 63;

  localparam logic [30:0]       PEAK_RESET     = 31'h7FFF_FFFF;
  localparam logic [5:0]        HEADROOM_RESET = 6'd0;
  localparam logic [BAND_W-1:0] ODD_BAND_FIRST = 12'd1;
  localparam logic [BAND_W-1:0] BAND_STEP      = 12'd2;

  // Register indexes on the configuration port
  localparam logic REG_PEAK_WEIGHT    = 1'b0;
  localparam logic REG_HEADROOM_SHIFT = 1'b1;

  // Per-item control decided by the front part
  typedef struct packed {
    logic              first;
    logic              emit_even;
    logic              emit_odd;
    logic [BAND_W-1:0] band;
  } cmf_ctl_t;

  // One classified item in the queue
  typedef struct packed {
    cmf_ctl_t           ctl;
    logic signed [31:0] bin_value;
    logic [30:0]        even_weight;
    logic signed [31:0] odd_weight;
  } cmf_entry_t;

endpackage
`default_nettype wire

// File: rtl/core/cmf_front.sv
// Front part: accepts bins, tracks band counters and odd weighting, classifies items.
`timescale 1ns / 1ps
`default_nettype none
module cmf_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                in_first,
  input  wire logic signed [31:0]  in_bin,
  input  wire logic [30:0]         in_weight,
  input  wire logic [30:0]         peak_weight,
  input  wire logic                q_full,
  output logic                     q_push,
  output cmf_pkg::cmf_entry_t      q_entry
);

  logic                        odd_active;
  logic                        odd_active_next;
  logic [cmf_pkg::BAND_W-1:0]  even_band;
  logic [cmf_pkg::BAND_W-1:0]  even_band_next;
  logic [cmf_pkg::BAND_W-1:0]  odd_band;
  logic [cmf_pkg::BAND_W-1:0]  odd_band_next;
  logic                        cur_active;
  logic [cmf_pkg::BAND_W-1:0]  cur_even;
  logic [cmf_pkg::BAND_W-1:0]  cur_odd;
  logic                        emit_even;
  logic                        emit_odd;
  logic                        at_peak;

  // Refuse items while the queue is full or reset holds the state
  assign in_ready = !q_full && !rst;
  assign q_push   = in_valid && in_ready;

  // Classify the item against the state left by the previous one
  always_comb begin
    cur_active = in_first ? 1'b0 : odd_active;
    cur_even   = in_first ? '0 : even_band;
    cur_odd    = in_first ? cmf_pkg::ODD_BAND_FIRST : odd_band;
    at_peak    = (in_weight == peak_weight);
    emit_even  = (in_weight == 31'd0) && !in_first;
    even_band_next = emit_even ? cur_even + cmf_pkg::BAND_STEP : cur_even;
    emit_odd   = at_peak && (even_band_next != '0) && !emit_even;
    odd_band_next  = emit_odd ? cur_odd + cmf_pkg::BAND_STEP : cur_odd;
    odd_active_next = cur_active || at_peak;

    q_entry.ctl.first     = in_first;
    q_entry.ctl.emit_even = emit_even;
    q_entry.ctl.emit_odd  = emit_odd;
    q_entry.ctl.band      = emit_even ? cur_even : cur_odd;
    q_entry.bin_value     = in_bin;
    q_entry.even_weight   = in_weight;
    q_entry.odd_weight    = cur_active ? ({1'b0, peak_weight} - {1'b0, in_weight}) : 32'sd0;
  end

  // Advance frame state on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      odd_active <= 1'b0;
      even_band  <= '0;
      odd_band   <= cmf_pkg::ODD_BAND_FIRST;
    end else if (q_push) begin
      odd_active <= odd_active_next;
      even_band  <= even_band_next;
      odd_band   <= odd_band_next;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/cmf_queue.sv
// Short first-word-fall-through queue between the front and back parts.
`timescale 1ns / 1ps
`default_nettype none
module cmf_queue #(
  parameter int DEPTH = cmf_pkg::QUEUE_DEPTH
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire cmf_pkg::cmf_entry_t push_entry,
  output logic                     full,
  input  wire logic                pop,
  output logic                     head_valid,
  output cmf_pkg::cmf_entry_t      head_entry
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  cmf_pkg::cmf_entry_t slots [DEPTH];
  logic [PTR_W-1:0]    wr_ptr;
  logic [PTR_W-1:0]    rd_ptr;
  logic [CNT_W-1:0]    count;
  logic                do_pop;

  assign full       = (count == FULL_CNT);
  assign head_valid = (count != '0);
  assign head_entry = slots[rd_ptr];
  assign do_pop     = pop && head_valid;

  // Store pushed entries
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Move pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= FULL_CNT)
    else $error("queue occupancy above depth");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("push into full queue");
`endif

endmodule
`default_nettype wire

// File: rtl/core/cmf_back.sv
// Back part: multiply, scale and accumulate each bin, drive the result register.
`timescale 1ns / 1ps
`default_nettype none
module cmf_back (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic [5:0]                 headroom_shift,
  input  wire logic                       head_valid,
  input  wire cmf_pkg::cmf_entry_t        head_entry,
  output logic                            pop,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [cmf_pkg::BAND_W-1:0]      out_index,
  output logic signed [31:0]              out_value
);

  logic                advance;
  logic [6:0]          shift_sum;
  logic [5:0]          shift_amt;

  // Stage A: products
  logic                va;
  cmf_pkg::cmf_ctl_t   ctl_a;
  logic signed [63:0]  prod_e;
  logic signed [63:0]  prod_o;
  logic signed [31:0]  even_w;

  // Stage B: scaled products
  logic                vb;
  cmf_pkg::cmf_ctl_t   ctl_b;
  logic signed [31:0]  scl_e;
  logic signed [31:0]  scl_o;
  logic signed [63:0]  shf_e;
  logic signed [63:0]  shf_o;

  // Stage C: accumulators
  logic signed [31:0]  even_sum;
  logic signed [31:0]  odd_sum;
  logic signed [31:0]  sum_e;
  logic signed [31:0]  sum_o;

  // Freeze the whole pipeline while a result waits
  assign advance = !out_valid || out_ready;
  assign pop     = advance && head_valid;

  always_comb begin
    shift_sum = 7'(headroom_shift) + 7'(cmf_pkg::FRAC_SHIFT);
    shift_amt = (shift_sum > 7'(cmf_pkg::MAX_SHIFT)) ? 6'(cmf_pkg::MAX_SHIFT) : shift_sum[5:0];
    even_w    = $signed({1'b0, head_entry.even_weight});
    shf_e     = prod_e >>> shift_amt;
    shf_o     = prod_o >>> shift_amt;
    sum_e     = (ctl_b.first ? 32'sd0 : even_sum) + scl_e;
    sum_o     = (ctl_b.first ? 32'sd0 : odd_sum) + scl_o;
  end

  // Pipeline stages A and B
  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
    end else if (advance) begin
      va <= head_valid;
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ctl_a  <= head_entry.ctl;
      prod_e <= 64'(head_entry.bin_value) * 64'(even_w);
      prod_o <= 64'(head_entry.bin_value) * 64'(head_entry.odd_weight);
      ctl_b  <= ctl_a;
      scl_e  <= shf_e[31:0];
      scl_o  <= shf_o[31:0];
    end
  end

  // Stage C: accumulate, emit and clear
  always_ff @(posedge clk) begin
    if (rst) begin
      even_sum  <= '0;
      odd_sum   <= '0;
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= vb && (ctl_b.emit_even || ctl_b.emit_odd);
      if (vb) begin
        even_sum <= ctl_b.emit_even ? 32'sd0 : sum_e;
        odd_sum  <= ctl_b.emit_odd ? 32'sd0 : sum_o;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && vb) begin
      out_index <= ctl_b.band;
      out_value <= ctl_b.emit_even ? sum_e : sum_o;
    end
  end

`ifndef NO_ASSERTIONS
  a_one_emit: assert property (@(posedge clk) disable iff (rst)
      vb |-> !(ctl_b.emit_even && ctl_b.emit_odd))
    else $error("even and odd emission on one bin");
  a_first_no_even: assert property (@(posedge clk) disable iff (rst)
      (vb && ctl_b.first) |-> !ctl_b.emit_even)
    else $error("even emission on a first bin");
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid && !va && !vb)
    else $error("pipeline not empty after reset");
  a_stall_pop: assert property (@(posedge clk) disable iff (rst)
      (out_valid && !out_ready) |-> !pop)
    else $error("queue popped while output stalled");
`endif

endmodule
`default_nettype wire

// File: rtl/core/compact_mel_filterbank_unit.sv
// Top level of the compact mel filterbank: channels, configuration registers, parts.
//
//   channel   dir  handshake           payload
//   s_*       in   s_tvalid/s_tready   tdata {even_weight, bin_value}, tuser first_bin
//   m_*       out  m_tvalid/m_tready   tdata {mel_value, mel_index}
//   apb       in   psel/penable        peak_weight @0x0, headroom_shift @0x4
//
// One bin accepted per cycle while the queue is not full; each bin passes the queue
// and three back stages (multiply, scale, accumulate) on the way to the result register.
// The accumulate stage holds the back part's only item-to-item loop: one 32-bit add.
// Reset is synchronous and needs no clearing pass; s_tready stays low in reset
// and rises in the first cycle after it.
// A stalled m_tready freezes the back stages; the queue of QUEUE_DEPTH items
// then fills and s_tready drops.
`timescale 1ns / 1ps
`default_nettype none
module compact_mel_filterbank_unit #(
  parameter int QUEUE_DEPTH = cmf_pkg::QUEUE_DEPTH
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [63:0]  s_tdata,   // [31:0] bin_value, [62:32] even_weight, [63] zero
  input  wire logic         s_tuser,   // [0] first_bin
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [47:0]       m_tdata,   // [11:0] mel_index, [43:12] mel_value, [47:44] zero
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [30:0]                 peak_weight;
  logic [5:0]                  headroom_shift;
  logic                        cfg_write;
  logic                        q_full;
  logic                        q_push;
  cmf_pkg::cmf_entry_t         q_entry;
  logic                        q_pop;
  logic                        head_valid;
  cmf_pkg::cmf_entry_t         head_entry;
  logic [cmf_pkg::BAND_W-1:0]  mel_index;
  logic signed [31:0]          mel_value;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      peak_weight    <= cmf_pkg::PEAK_RESET;
      headroom_shift <= cmf_pkg::HEADROOM_RESET;
    end else if (cfg_write) begin
      case (paddr[2])
        cmf_pkg::REG_PEAK_WEIGHT:    peak_weight    <= pwdata[30:0];
        cmf_pkg::REG_HEADROOM_SHIFT: headroom_shift <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (paddr[2])
      cmf_pkg::REG_PEAK_WEIGHT:    prdata = {1'b0, peak_weight};
      cmf_pkg::REG_HEADROOM_SHIFT: prdata = {26'd0, headroom_shift};
      default:                     prdata = '0;
    endcase
  end

  cmf_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_first    (s_tuser),
    .in_bin      ($signed(s_tdata[31:0])),
    .in_weight   (s_tdata[62:32]),
    .peak_weight (peak_weight),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_entry     (q_entry)
  );

  cmf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  cmf_back u_back (
    .clk            (clk),
    .rst            (rst),
    .headroom_shift (headroom_shift),
    .head_valid     (head_valid),
    .head_entry     (head_entry),
    .pop            (q_pop),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .out_index      (mel_index),
    .out_value      (mel_value)
  );

  assign m_tdata = {4'd0, mel_value, mel_index};

endmodule
`default_nettype wire

// File: verif/testbench.sv
// Self-checking testbench for the compact mel filterbank unit.
`timescale 1ns / 1ps
module testbench;

  localparam logic [2:0] ADDR_PEAK     = {cmf_pkg::REG_PEAK_WEIGHT, 2'b00};
  localparam logic [2:0] ADDR_HEADROOM = {cmf_pkg::REG_HEADROOM_SHIFT, 2'b00};
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic [cmf_pkg::BAND_W-1:0] idx;
    logic [31:0]                value;
  } mel_band_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  wire         s_tready;
  logic [63:0] s_tdata = '0;   // [31:0] bin_value, [62:32] even_weight, [63] zero
  logic        s_tuser = 1'b0; // [0] first_bin
  wire         m_tvalid;
  logic        m_tready = 1'b0;
  wire  [47:0] m_tdata;        // [11:0] mel_index, [43:12] mel_value, [47:44] zero
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  wire  [31:0] prdata;
  wire         pready;

  // Register copies and filterbank state of the predictor
  logic [30:0]                peak_cfg  = cmf_pkg::PEAK_RESET;
  logic [5:0]                 shift_cfg = cmf_pkg::HEADROOM_RESET;
  logic [31:0]                even_acc  = '0;
  logic [31:0]                odd_acc   = '0;
  logic [cmf_pkg::BAND_W-1:0] even_idx  = '0;
  logic [cmf_pkg::BAND_W-1:0] odd_idx   = cmf_pkg::ODD_BAND_FIRST;
  bit                         odd_on    = 1'b0;

  mel_band_t pending_bands[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit recv_hold      = 1'b0;
  int bins_sent      = 0;
  int bands_seen     = 0;
  int settings_used  = 0;
  int mismatches     = 0;
  int cycle_count    = 0;

  compact_mel_filterbank_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #2 clk = ~clk;

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out with %0d bands still pending", pending_bands.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Stall the result side at random unless a drain holds it open
  always @(posedge clk) begin
    if (recv_hold || recv_stall_pct == 0) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Scale one product: floor shift by headroom + 31, capped at 63, keep low 32 bits
  function automatic logic [31:0] mel_product(logic signed [31:0] bin, longint w);
    logic signed [63:0] p;
    logic signed [63:0] shifted;
    int unsigned        sh;
    p = longint'(bin) * w;
    sh = shift_cfg + cmf_pkg::FRAC_SHIFT;
    if (sh > cmf_pkg::MAX_SHIFT) sh = cmf_pkg::MAX_SHIFT;
    shifted = p >>> sh;
    return shifted[31:0];
  endfunction

  // Advance the filterbank by one bin; return 1 when a band completes
  function automatic bit band_from_bin(bit first, logic signed [31:0] bin,
                                       logic [30:0] ew, output mel_band_t band);
    longint odd_w;
    bit     done;
    done = 1'b0;
    band = '0;
    if (first) begin
      even_acc = '0;
      odd_acc  = '0;
      even_idx = '0;
      odd_idx  = cmf_pkg::ODD_BAND_FIRST;
      odd_on   = 1'b0;
    end
    odd_w = odd_on ? longint'(peak_cfg) - longint'(ew) : 0;
    even_acc = even_acc + mel_product(bin, longint'(ew));
    odd_acc  = odd_acc + mel_product(bin, odd_w);
    // Zero weight closes the even band
    if (ew == 31'd0 && !first) begin
      band = '{even_idx, even_acc};
      done = 1'b1;
      even_acc = '0;
      even_idx = even_idx + cmf_pkg::BAND_STEP;
    end
    // Peak weight turns on odd weighting and closes the odd band once an even one left
    if (ew == peak_cfg) begin
      odd_on = 1'b1;
      if (even_idx != '0 && !done) begin
        band = '{odd_idx, odd_acc};
        done = 1'b1;
        odd_acc = '0;
        odd_idx = odd_idx + cmf_pkg::BAND_STEP;
      end
    end
    return done;
  endfunction

  // Compare each delivered band with the oldest prediction
  always @(posedge clk) begin : check_bands
    mel_band_t want;
    logic [cmf_pkg::BAND_W-1:0] got_idx;
    logic [31:0]                got_val;
    if (!rst && m_tvalid && m_tready) begin
      got_idx = m_tdata[11:0];
      got_val = m_tdata[43:12];
      bands_seen++;
      if (pending_bands.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("[%0t] unexpected band: index %0d value %0d", $realtime,
                   got_idx, $signed(got_val));
      end else begin
        want = pending_bands.pop_front();
        if (got_idx !== want.idx || got_val !== want.value) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("[%0t] band mismatch: expected index %0d value %0d, got index %0d value %0d",
                     $realtime, want.idx, $signed(want.value), got_idx, $signed(got_val));
        end
      end
    end
  end

  // Offer one bin, wait for its acceptance, then record its prediction
  task automatic send_bin(bit first, logic [31:0] bin, logic [30:0] ew);
    mel_band_t band;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, ew, bin};
    s_tuser  <= first;
    do @(posedge clk); while (!s_tready);
    bins_sent++;
    if (band_from_bin(first, bin, ew, band)) pending_bands.push_back(band);
  endtask

  // Drop valid, let every band arrive, then let the pipeline empty
  task automatic wait_quiet();
    s_tvalid <= 1'b0;
    recv_hold = 1'b1;
    while (pending_bands.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    recv_hold = 1'b0;
  endtask

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_config(logic [30:0] peak, logic [5:0] shift);
    apb_write(ADDR_PEAK, {1'b0, peak});
    peak_cfg = peak;
    apb_write(ADDR_HEADROOM, {26'd0, shift});
    shift_cfg = shift;
    settings_used++;
  endtask

  function automatic logic [31:0] pick_bin();
    if ($urandom_range(7) == 0) begin
      case ($urandom_range(3))
        0: return 32'h8000_0000;
        1: return 32'h7FFF_FFFF;
        2: return 32'hFFFF_FFFF;
        default: return 32'h0;
      endcase
    end
    return $urandom;
  endfunction

  // Weight strictly between zero and the peak where one exists
  function automatic logic [30:0] pick_mid();
    if (peak_cfg >= 31'd2) return 31'($urandom_range(peak_cfg - 31'd1, 1));
    return peak_cfg;
  endfunction

  function automatic logic [30:0] pick_noise_weight();
    case ($urandom_range(3))
      0: return 31'd0;
      1: return peak_cfg;
      2: return pick_mid();
      default: return 31'($urandom);
    endcase
  endfunction

  // Send a well-formed spectrum: rise to the peak, fall to zero, per band pair
  task automatic send_frame(int pairs);
    int k;
    send_bin(1'b1, pick_bin(), $urandom_range(1) ? 31'd0 : pick_mid());
    for (int b = 0; b < pairs; b++) begin
      k = $urandom_range(3);
      repeat (k) send_bin(1'b0, pick_bin(), pick_mid());
      send_bin(1'b0, pick_bin(), peak_cfg);
      k = $urandom_range(3);
      repeat (k) send_bin(1'b0, pick_bin(), pick_mid());
      send_bin(1'b0, pick_bin(), 31'd0);
    end
  endtask

  // Stream without a first mark straight after reset, default registers
  task automatic test_reset_state();
    send_bin(1'b0, 32'd100000, 31'h4000_0000);
    send_bin(1'b0, 32'h7FFF_FFFF, cmf_pkg::PEAK_RESET);
    send_bin(1'b0, 32'h8000_0000, 31'd0);
    send_bin(1'b0, 32'd98765, 31'd1234);
    send_bin(1'b0, 32'hFFFF_0000, cmf_pkg::PEAK_RESET);
    send_bin(1'b0, 32'h8000_0000, 31'd0);
  endtask

  task automatic test_directed_cases();
    // Small peak: zero weight on a first bin, negative odd weight
    wait_quiet();
    set_config(31'd1000, 6'd0);
    send_bin(1'b1, 32'h7FFF_FFFF, 31'd0);
    send_bin(1'b0, 32'h7FFF_FFFF, 31'd500);
    send_bin(1'b0, 32'h8000_0000, 31'd1000);
    send_bin(1'b0, 32'h8000_0000, 31'd0);
    send_bin(1'b0, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
    send_bin(1'b0, 32'd12345, 31'd1000);
    // Largest peak with wide headroom
    wait_quiet();
    set_config(cmf_pkg::PEAK_RESET, 6'd32);
    send_bin(1'b1, 32'h8000_0000, cmf_pkg::PEAK_RESET);
    send_bin(1'b0, 32'h8000_0000, 31'd0);
    send_bin(1'b0, 32'h7FFF_FFFF, cmf_pkg::PEAK_RESET);
    // Shift beyond the 64-bit product
    wait_quiet();
    set_config(cmf_pkg::PEAK_RESET, 6'd63);
    send_bin(1'b1, 32'h8000_0000, cmf_pkg::PEAK_RESET);
    send_bin(1'b0, 32'hFFFF_FFFF, 31'd1);
    send_bin(1'b0, 32'h0, 31'd0);
    // Zero peak: zero weight is both band end and peak
    wait_quiet();
    set_config(31'd0, 6'd5);
    send_bin(1'b1, 32'h7FFF_FFFF, 31'd0);
    send_bin(1'b0, 32'h8000_0000, 31'h7FFF_FFFF);
    send_bin(1'b0, 32'd5, 31'd0);
    send_bin(1'b0, 32'd9, 31'd0);
  endtask

  // Mostly well-formed spectra with random content, the rest noise and broken frames
  task automatic test_random_stream(logic [30:0] peak, logic [5:0] shift, int count);
    int target;
    wait_quiet();
    set_config(peak, shift);
    target = bins_sent + count;
    while (bins_sent < target) begin
      if ($urandom_range(4) != 0) begin
        send_frame($urandom_range(6, 1));
      end else begin
        repeat ($urandom_range(8, 1))
          send_bin($urandom_range(9) == 0, pick_bin(), pick_noise_weight());
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct  = 10;
    recv_stall_pct = 73;
    test_reset_state();
    test_directed_cases();
    test_random_stream(cmf_pkg::PEAK_RESET, 6'd0, 130);
    test_random_stream(31'd1, 6'd32, 130);

    send_idle_pct  = 73;
    recv_stall_pct = 10;
    test_random_stream(31'($urandom), 6'($urandom_range(32)), 130);
    test_random_stream(cmf_pkg::PEAK_RESET, 6'd32, 130);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_stream(31'($urandom_range(1000, 16)), 6'd0, 130);
    test_random_stream(31'($urandom), 6'd63, 130);

    wait_quiet();
    $display("Sent %0d bins under %0d register settings; checked %0d mel bands, %0d mismatches.",
             bins_sent, settings_used, bands_seen, mismatches);
    $display("Covered frame restarts, odd weighting, zero peak, shifts 0..63, stalls.");
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: compact_mel_filterbank_unit.f
rtl/core/cmf_pkg.sv
rtl/core/cmf_front.sv
rtl/core/cmf_queue.sv
rtl/core/cmf_back.sv
rtl/core/compact_mel_filterbank_unit.sv
verif/testbench.sv
